FILE: rtl/atilt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atilt_pkg: shared types and constants for the tilt angle pipeline
// Widths of the normalized magnitudes, square root, CORDIC datapath and the
// arctangent table used by the vectoring stages.
// ----------------------------------------------------------------------------
package atilt_pkg;

	localparam int AXIS_WIDTH_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int NORM_W     = 30;
	localparam int NORM_MSB   = 29;
	localparam int SQ_W       = 62;
	localparam int ROOT_W     = 31;
	localparam int SQRT_STEPS = 31;
	localparam int CORD_W     = 34;
	localparam int ANG_W      = 32;
	localparam int ANG_FRAC   = 16;
	localparam int MAG_W      = 14;
	localparam int ANGLE_W    = 16;

	localparam logic [MAG_W-1:0]          MAG_FULL  = 14'd9000;
	localparam logic signed [ANGLE_W-1:0] HALF_TURN = 16'sd18000;

	typedef struct packed {
		logic y_neg;
		logic y_zero;
		logic z_neg;
		logic z_zero;
		logic force_zero;
		logic force_full;
	} ctl_t;

	function automatic logic signed [ANG_W-1:0] atan_step(input int i);
		logic signed [ANG_W-1:0] v;
		case (i)
			0: v = 32'sd294912000;
			1: v = 32'sd174096719;
			2: v = 32'sd91987925;
			3: v = 32'sd46694507;
			4: v = 32'sd23437865;
			5: v = 32'sd11730358;
			6: v = 32'sd5866610;
			7: v = 32'sd2933484;
			8: v = 32'sd1466764;
			9: v = 32'sd733385;
			10: v = 32'sd366693;
			11: v = 32'sd183346;
			12: v = 32'sd91673;
			13: v = 32'sd45837;
			14: v = 32'sd22918;
			15: v = 32'sd11459;
			16: v = 32'sd5730;
			17: v = 32'sd2865;
			18: v = 32'sd1432;
			19: v = 32'sd716;
			20: v = 32'sd358;
			21: v = 32'sd179;
			22: v = 32'sd90;
			23: v = 32'sd45;
			24: v = 32'sd22;
			25: v = 32'sd11;
			26: v = 32'sd6;
			27: v = 32'sd3;
			28: v = 32'sd1;
			29: v = 32'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/atilt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atilt_if: valid/ready channels of the tilt angle block
// Axis sample channel and angle result channel.
// ----------------------------------------------------------------------------
interface atilt_axis_if #(parameter int AXIS_WIDTH = atilt_pkg::AXIS_WIDTH_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [AXIS_WIDTH-1:0] axis_x;
	logic signed [AXIS_WIDTH-1:0] axis_y;
	logic signed [AXIS_WIDTH-1:0] axis_z;
	modport source (output valid, output axis_x, output axis_y, output axis_z, input ready);
	modport sink (input valid, input axis_x, input axis_y, input axis_z, output ready);
endinterface

interface atilt_angle_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [atilt_pkg::ANGLE_W-1:0] angle_centideg;
	modport source (output valid, output angle_centideg, input ready);
	modport sink (input valid, input angle_centideg, output ready);
endinterface
`default_nettype wire

FILE: rtl/atilt_norm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atilt_norm: magnitude and common power-of-two normalization
// Three stages: absolute values, leading one of the largest magnitude,
// shift of all three magnitudes so the largest sits in bit 29.
// ----------------------------------------------------------------------------
module atilt_norm #(
	parameter int AXIS_WIDTH = atilt_pkg::AXIS_WIDTH_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  en,
	input  wire                                  in_valid,
	input  wire logic signed [AXIS_WIDTH-1:0]    axis_x,
	input  wire logic signed [AXIS_WIDTH-1:0]    axis_y,
	input  wire logic signed [AXIS_WIDTH-1:0]    axis_z,
	output logic                                 out_valid,
	output logic [atilt_pkg::NORM_W-1:0]         nx,
	output logic [atilt_pkg::NORM_W-1:0]         ny,
	output logic [atilt_pkg::NORM_W-1:0]         nz,
	output atilt_pkg::ctl_t                      ctl
);

	localparam int PW    = (AXIS_WIDTH > 1) ? $clog2(AXIS_WIDTH) : 1;
	localparam int EXT_W = AXIS_WIDTH + atilt_pkg::NORM_MSB;

	logic                   valid_s1, valid_s2, valid_s3;
	logic [AXIS_WIDTH-1:0]  mx_s1, my_s1, mz_s1;
	logic [AXIS_WIDTH-1:0]  mx_s2, my_s2, mz_s2;
	atilt_pkg::ctl_t        ctl_s1, ctl_s2, ctl_s3;
	logic [PW-1:0]          msb_s2;
	logic                   mzero_s2;
	logic [atilt_pkg::NORM_W-1:0] nx_s3, ny_s3, nz_s3;

	logic [AXIS_WIDTH-1:0] mx, my, mz, mmax;
	logic [PW-1:0]         msb;
	atilt_pkg::ctl_t       ctl_in;
	atilt_pkg::ctl_t       ctl_n;
	logic [EXT_W-1:0]      ex, ey, ez;
	logic [atilt_pkg::NORM_W-1:0] sx, sy, sz;

	always_comb begin
		mx = axis_x[AXIS_WIDTH-1] ? (~axis_x + 1'b1) : axis_x;
		my = axis_y[AXIS_WIDTH-1] ? (~axis_y + 1'b1) : axis_y;
		mz = axis_z[AXIS_WIDTH-1] ? (~axis_z + 1'b1) : axis_z;
		ctl_in            = '0;
		ctl_in.y_neg      = axis_y[AXIS_WIDTH-1];
		ctl_in.y_zero     = (axis_y == '0);
		ctl_in.z_neg      = axis_z[AXIS_WIDTH-1];
		ctl_in.z_zero     = (axis_z == '0);
	end

	always_comb begin
		mmax = mx_s1;
		if (my_s1 > mmax) mmax = my_s1;
		if (mz_s1 > mmax) mmax = mz_s1;
		msb = '0;
		for (int i = 0; i < AXIS_WIDTH; i++) begin
			if (mmax[i]) msb = PW'(i);
		end
	end

	always_comb begin
		ex = {mx_s2, {atilt_pkg::NORM_MSB{1'b0}}} >> msb_s2;
		ey = {my_s2, {atilt_pkg::NORM_MSB{1'b0}}} >> msb_s2;
		ez = {mz_s2, {atilt_pkg::NORM_MSB{1'b0}}} >> msb_s2;
		sx = ex[atilt_pkg::NORM_W-1:0];
		sy = ey[atilt_pkg::NORM_W-1:0];
		sz = ez[atilt_pkg::NORM_W-1:0];
		ctl_n            = ctl_s2;
		ctl_n.force_zero = mzero_s2 || (sy == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1    <= mx;
			my_s1    <= my;
			mz_s1    <= mz;
			ctl_s1   <= ctl_in;
			mx_s2    <= mx_s1;
			my_s2    <= my_s1;
			mz_s2    <= mz_s1;
			msb_s2   <= msb;
			mzero_s2 <= (mmax == '0);
			ctl_s2   <= ctl_s1;
			nx_s3    <= sx;
			ny_s3    <= sy;
			nz_s3    <= sz;
			ctl_s3   <= ctl_n;
		end
	end

	assign out_valid = valid_s3;
	assign nx        = nx_s3;
	assign ny        = ny_s3;
	assign nz        = nz_s3;
	assign ctl       = ctl_s3;

`ifndef SYNTH
	a_norm_top_bit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !(nx_s3 == '0 && ny_s3 == '0 && nz_s3 == '0) |->
		(nx_s3[atilt_pkg::NORM_MSB] || ny_s3[atilt_pkg::NORM_MSB] ||
		 nz_s3[atilt_pkg::NORM_MSB]))
		else $error("normalized maximum lost its top bit");
`endif

endmodule
`default_nettype wire

FILE: rtl/atilt_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atilt_sqrt: pipelined integer square root of x*x + z*z
// Squares, sum, then one result bit per stage over 31 restoring stages.
// ----------------------------------------------------------------------------
module atilt_sqrt (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 en,
	input  wire                                 in_valid,
	input  wire logic [atilt_pkg::NORM_W-1:0]   nx,
	input  wire logic [atilt_pkg::NORM_W-1:0]   ny,
	input  wire logic [atilt_pkg::NORM_W-1:0]   nz,
	input  wire atilt_pkg::ctl_t                in_ctl,
	output logic                                out_valid,
	output logic [atilt_pkg::ROOT_W-1:0]        root,
	output logic [atilt_pkg::NORM_W-1:0]        out_ny,
	output atilt_pkg::ctl_t                     out_ctl
);

	localparam int N = atilt_pkg::SQRT_STEPS;
	localparam int W = atilt_pkg::SQ_W;

	logic                          valid_s1, valid_s2;
	logic [2*atilt_pkg::NORM_W-1:0] xx_s1, zz_s1;
	logic [atilt_pkg::NORM_W-1:0]  ny_s1, ny_s2;
	atilt_pkg::ctl_t               ctl_s1, ctl_s2;
	logic [W-1:0]                  sum_s2;

	logic                          valid_s [0:N];
	logic [W-1:0]                  rem_s   [0:N];
	logic [W-1:0]                  res_s   [0:N];
	logic [atilt_pkg::NORM_W-1:0]  nyp_s   [0:N];
	atilt_pkg::ctl_t               ctlp_s  [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1  <= nx * nx;
			zz_s1  <= nz * nz;
			ny_s1  <= ny;
			ctl_s1 <= in_ctl;
			sum_s2 <= W'(xx_s1) + W'(zz_s1);
			ny_s2  <= ny_s1;
			ctl_s2 <= ctl_s1;
		end
	end

	assign valid_s[0] = valid_s2;
	assign rem_s[0]   = sum_s2;
	assign res_s[0]   = '0;
	assign nyp_s[0]   = ny_s2;
	assign ctlp_s[0]  = ctl_s2;

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - k));
		logic [W-1:0] trial;
		assign trial = res_s[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[k] >= trial) begin
					rem_s[k+1] <= rem_s[k] - trial;
					res_s[k+1] <= (res_s[k] >> 1) + BIT;
				end else begin
					rem_s[k+1] <= rem_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
				nyp_s[k+1]  <= nyp_s[k];
				ctlp_s[k+1] <= ctlp_s[k];
			end
		end
	end

	always_comb begin
		out_ctl            = ctlp_s[N];
		out_ctl.force_full = (res_s[N] == '0);
	end

	assign out_valid = valid_s[N];
	assign root      = res_s[N][atilt_pkg::ROOT_W-1:0];
	assign out_ny    = nyp_s[N];

`ifndef SYNTH
	a_root_width: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[N] |-> (res_s[N][W-1:atilt_pkg::ROOT_W] == '0))
		else $error("square root exceeds its width");
`endif

endmodule
`default_nettype wire

FILE: rtl/atilt_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atilt_cordic: unrolled CORDIC vectoring pipeline
// One micro-rotation per stage, then rounding to hundredths of a degree
// and limiting to 0..9000, with the zero and full-angle cases applied.
// ----------------------------------------------------------------------------
module atilt_cordic #(
	parameter int CORDIC_STEPS = atilt_pkg::CORDIC_STEPS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 en,
	input  wire                                 in_valid,
	input  wire logic [atilt_pkg::ROOT_W-1:0]   root,
	input  wire logic [atilt_pkg::NORM_W-1:0]   ny,
	input  wire atilt_pkg::ctl_t                in_ctl,
	output logic                                out_valid,
	output logic [atilt_pkg::MAG_W-1:0]         mag,
	output atilt_pkg::ctl_t                     out_ctl
);

	localparam int N  = CORDIC_STEPS;
	localparam int CW = atilt_pkg::CORD_W;
	localparam int AW = atilt_pkg::ANG_W;

	logic                    valid_s [0:N];
	logic signed [CW-1:0]    cx_s    [0:N];
	logic signed [CW-1:0]    cy_s    [0:N];
	logic signed [AW-1:0]    ang_s   [0:N];
	atilt_pkg::ctl_t         ctl_s   [0:N];

	logic                        valid_r_s;
	logic [atilt_pkg::MAG_W-1:0] mag_r_s;
	atilt_pkg::ctl_t             ctl_r_s;

	logic signed [AW-1:0]        rounded;
	logic [atilt_pkg::MAG_W-1:0] clamped;

	assign valid_s[0] = in_valid;
	assign cx_s[0]    = CW'(root);
	assign cy_s[0]    = CW'(ny);
	assign ang_s[0]   = '0;
	assign ctl_s[0]   = in_ctl;

	for (genvar k = 0; k < N; k++) begin : g_rot
		localparam logic signed [AW-1:0] ATAN = atilt_pkg::atan_step(k);
		logic signed [CW-1:0] dx, dy;
		assign dx = cy_s[k] >>> k;
		assign dy = cx_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy_s[k][CW-1]) begin
					cx_s[k+1]  <= cx_s[k] + dx;
					cy_s[k+1]  <= cy_s[k] - dy;
					ang_s[k+1] <= ang_s[k] + ATAN;
				end else begin
					cx_s[k+1]  <= cx_s[k] - dx;
					cy_s[k+1]  <= cy_s[k] + dy;
					ang_s[k+1] <= ang_s[k] - ATAN;
				end
				ctl_s[k+1] <= ctl_s[k];
			end
		end
	end

	always_comb begin
		rounded = (ang_s[N] + (AW'(1) <<< (atilt_pkg::ANG_FRAC - 1))) >>> atilt_pkg::ANG_FRAC;
		if (ctl_s[N].force_zero || rounded < 0) begin
			clamped = '0;
		end else if (ctl_s[N].force_full || rounded > AW'(atilt_pkg::MAG_FULL)) begin
			clamped = atilt_pkg::MAG_FULL;
		end else begin
			clamped = rounded[atilt_pkg::MAG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_r_s <= 1'b0;
		end else if (en) begin
			valid_r_s <= valid_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_r_s <= clamped;
			ctl_r_s <= ctl_s[N];
		end
	end

	assign out_valid = valid_r_s;
	assign mag       = mag_r_s;
	assign out_ctl   = ctl_r_s;

`ifndef SYNTH
	a_zero_mag: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s[N] && ctl_s[N].force_zero |=> (mag_r_s == '0))
		else $error("forced zero angle not honored");
`endif

endmodule
`default_nettype wire

FILE: rtl/accel_tilt_angle.sv
`default_nettype none
// ----------------------------------------------------------------------------
// accel_tilt_angle: accelerometer tilt angle in hundredths of a degree
// Normalize, square root, CORDIC vectoring and quadrant folding.
// ----------------------------------------------------------------------------
// A fully pipelined datapath takes one sample per cycle unless the output
// holds it, and returns one angle per sample, in order, through three
// normalization stages, two for the squares and their sum, 31 square root
// stages, CORDIC_STEPS rotation stages, one rounding stage and one folding
// stage that doubles as the output register. The whole pipeline holds while
// a result waits on the output.
// ----------------------------------------------------------------------------
module accel_tilt_angle #(
	parameter int AXIS_WIDTH   = atilt_pkg::AXIS_WIDTH_DEF,
	parameter int CORDIC_STEPS = atilt_pkg::CORDIC_STEPS_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	atilt_axis_if.sink     axis,
	atilt_angle_if.source  angle
);

	logic en;

	logic                         n_valid;
	logic [atilt_pkg::NORM_W-1:0] n_x, n_y, n_z;
	atilt_pkg::ctl_t              n_ctl;

	logic                         s_valid;
	logic [atilt_pkg::ROOT_W-1:0] s_root;
	logic [atilt_pkg::NORM_W-1:0] s_y;
	atilt_pkg::ctl_t              s_ctl;

	logic                         c_valid;
	logic [atilt_pkg::MAG_W-1:0]  c_mag;
	atilt_pkg::ctl_t              c_ctl;

	logic                                 out_valid_s1;
	logic signed [atilt_pkg::ANGLE_W-1:0] out_angle_s1;
	logic signed [atilt_pkg::ANGLE_W-1:0] base, folded;

	assign en         = !out_valid_s1 || angle.ready;
	assign axis.ready = en;

	atilt_norm #(.AXIS_WIDTH(AXIS_WIDTH)) u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (axis.valid),
		.axis_x   (axis.axis_x),
		.axis_y   (axis.axis_y),
		.axis_z   (axis.axis_z),
		.out_valid(n_valid),
		.nx       (n_x),
		.ny       (n_y),
		.nz       (n_z),
		.ctl      (n_ctl)
	);

	atilt_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (n_valid),
		.nx       (n_x),
		.ny       (n_y),
		.nz       (n_z),
		.in_ctl   (n_ctl),
		.out_valid(s_valid),
		.root     (s_root),
		.out_ny   (s_y),
		.out_ctl  (s_ctl)
	);

	atilt_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_valid),
		.root     (s_root),
		.ny       (s_y),
		.in_ctl   (s_ctl),
		.out_valid(c_valid),
		.mag      (c_mag),
		.out_ctl  (c_ctl)
	);

	always_comb begin
		base = c_ctl.y_neg ? -atilt_pkg::ANGLE_W'(c_mag) : atilt_pkg::ANGLE_W'(c_mag);
		if ((c_ctl.y_neg || c_ctl.y_zero) && (c_ctl.z_neg || c_ctl.z_zero)) begin
			folded = base;
		end else if (c_ctl.y_neg) begin
			folded = -atilt_pkg::HALF_TURN - base;
		end else if (c_ctl.z_neg) begin
			folded = base;
		end else begin
			folded = atilt_pkg::HALF_TURN - base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (en) begin
			out_valid_s1 <= c_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_angle_s1 <= folded;
		end
	end

	assign angle.valid          = out_valid_s1;
	assign angle.angle_centideg = out_angle_s1;

`ifndef SYNTH
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s1 |-> (out_angle_s1 <= atilt_pkg::HALF_TURN &&
		out_angle_s1 >= -atilt_pkg::HALF_TURN))
		else $error("angle out of range");
	a_fold_half_turn: assert property (@(posedge clk) disable iff (!arst_n)
		en && c_valid && c_ctl.y_zero && !c_ctl.z_neg && !c_ctl.z_zero |=>
		(out_angle_s1 == atilt_pkg::HALF_TURN))
		else $error("flat positive z case not folded to a half turn");
`endif

endmodule
`default_nettype wire
